@@ sv/sacr_pkg.sv @@
// ----------------------------------------------------------------------------
// sacr_pkg: shared constants for the size-aware cache directory
// Register indexes, policy codes and result layout.
// ----------------------------------------------------------------------------
package sacr_pkg;

  localparam int unsigned RegPolicy   = 0;
  localparam int unsigned RegCapacity = 1;

  localparam logic [1:0] PolFifo    = 2'd0;
  localparam logic [1:0] PolLru     = 2'd1;
  localparam logic [1:0] PolLargest = 2'd2;

  localparam logic [31:0] CapReset = 32'd1048576;

  localparam int unsigned OutDataW = 136;
  localparam int unsigned InDataW  = 64;

  typedef struct packed {
    logic [31:0] request_total;
    logic [31:0] hit_total;
    logic [31:0] bytes_free;
    logic        was_stored;
    logic        was_hit;
    logic [31:0] evicted_key;
  } result_t;

endpackage

@@ sv/size_aware_cache_replacement.sv @@
// ----------------------------------------------------------------------------
// size_aware_cache_replacement: byte-capacity cache directory
// Looks up keys, counts hits, evicts by insertion order, recency or size.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (tdata = key, size). For each request the block
//   sends zero or more eviction reports (tuser = 1) and one final result
//   (tuser = 0, tlast = 1) on m_axis. Registers are to be written over APB only
//   while idle (the block does not enforce this): policy at 0x0, capacity at 0x4;
//   a capacity write flushes the table. One request is handled at a time. The
//   lookup scans the key and size memories one slot per cycle; each eviction
//   passes through the decide state, a new scan and the drop state; the final
//   result passes through the decide and final states.
//   Reset empties the directory, zeroes the counters, sets policy to
//   insertion order and capacity to 1 MiB; no clearing pass is needed.
//   A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module size_aware_cache_replacement #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request_key [31:0], object_size [63:32]
  input  logic [sacr_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // evicted_key [31:0], was_hit [32], was_stored [33], bytes_free [65:34],
  // hit_total [97:66], request_total [129:98], zero pad [135:130]
  output logic [sacr_pkg::OutDataW-1:0] m_axis_tdata,
  // is_eviction [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_VICT   = 3'd3;
  localparam logic [2:0] S_DROP   = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [1:0]           policy_q;
  logic [SIZE_BITS-1:0] cap_q;
  logic [SIZE_BITS-1:0] free_q;
  logic [31:0]          hit_cnt_q, req_cnt_q;

  logic [31:0]          key_mem  [SLOTS];
  logic [SIZE_BITS-1:0] size_mem [SLOTS];
  logic [31:0]          key_rd_q;
  logic [SIZE_BITS-1:0] size_rd_q;

  logic [SLOTS-1:0] valid_q;
  logic [IW-1:0]    rank_q [SLOTS];

  logic [CW-1:0] scan_cnt_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  logic [31:0]          req_key_q;
  logic [SIZE_BITS-1:0] req_size_q;
  logic                 hit_q;
  logic [IW-1:0]        hit_rank_q;
  logic                 free_found_q;
  logic [IW-1:0]        free_idx_q;
  logic                 best_found_q;
  logic [IW-1:0]        best_idx_q;
  logic [IW-1:0]        best_rank_q;
  logic [31:0]          best_key_q;
  logic [SIZE_BITS-1:0] best_size_q;
  logic [CW-1:0]        evict_cnt_q;

  logic                 out_vld_q;
  sacr_pkg::result_t    out_q;
  logic                 out_ev_q, out_last_q;

  logic cfg_wr, emit_ok, scan_done, do_store, need_evict, better;
  logic [SIZE_BITS-1:0] free_drop, free_ins;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = paddr[2] ? 32'(cap_q) : {30'd0, policy_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q};
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;

  assign emit_ok   = ~out_vld_q | m_axis_tready;
  assign scan_done = (scan_cnt_q == SlotsC) & ~rd_vld_q;
  assign free_drop = free_q + best_size_q;
  assign free_ins  = free_q - req_size_q;
  assign do_store  = ~hit_q & free_found_q & (req_size_q < free_q) & (req_size_q < cap_q);
  assign need_evict = ~(req_size_q < free_q) | ~free_found_q;

  // victim order: largest size with oldest on ties, else oldest
  always_comb begin
    if (policy_q == sacr_pkg::PolLargest) begin
      better = (size_rd_q > best_size_q) ||
               ((size_rd_q == best_size_q) && (rank_q[rd_idx_q] > best_rank_q));
    end else begin
      better = rank_q[rd_idx_q] > best_rank_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_LOOK;
      S_LOOK:   if (scan_done) state_d = S_DECIDE;
      S_DECIDE: begin
        priority if (hit_q || !(req_size_q < cap_q)) state_d = S_FINAL;
        else if (need_evict && evict_cnt_q < SlotsC) state_d = S_VICT;
        else state_d = S_FINAL;
      end
      S_VICT:   if (scan_done) state_d = best_found_q ? S_DROP : S_FINAL;
      S_DROP:   if (emit_ok) state_d = S_DECIDE;
      S_FINAL:  if (emit_ok) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // memories: one read port for the scan, one write port for inserts
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[scan_cnt_q[IW-1:0]];
    size_rd_q <= size_mem[scan_cnt_q[IW-1:0]];
    if (state_q == S_FINAL && emit_ok && do_store) begin
      key_mem[free_idx_q]  <= req_key_q;
      size_mem[free_idx_q] <= req_size_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      req_key_q  <= s_axis_tdata[31:0];
      req_size_q <= SIZE_BITS'(s_axis_tdata[63:32]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      policy_q     <= sacr_pkg::PolFifo;
      cap_q        <= SIZE_BITS'(sacr_pkg::CapReset);
      free_q       <= SIZE_BITS'(sacr_pkg::CapReset);
      hit_cnt_q    <= '0;
      req_cnt_q    <= '0;
      valid_q      <= '0;
      for (int i = 0; i < SLOTS; i++) rank_q[i] <= '0;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      hit_q        <= 1'b0;
      hit_rank_q   <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_rank_q  <= '0;
      best_key_q   <= '0;
      best_size_q  <= '0;
      evict_cnt_q  <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
      out_ev_q     <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DROP || state_q == S_FINAL) && emit_ok) out_vld_q <= 1'b1;
      else if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == 1'(sacr_pkg::RegCapacity)) begin
          cap_q   <= SIZE_BITS'(pwdata);
          free_q  <= SIZE_BITS'(pwdata);
          valid_q <= '0;
          for (int i = 0; i < SLOTS; i++) rank_q[i] <= '0;
        end else begin
          policy_q <= pwdata[1:0];
        end
      end

      // scan issue and read pipeline
      rd_vld_q <= (state_q == S_LOOK || state_q == S_VICT) && scan_cnt_q != SlotsC;
      if ((state_q == S_LOOK || state_q == S_VICT) && scan_cnt_q != SlotsC) begin
        rd_idx_q   <= scan_cnt_q[IW-1:0];
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_cnt_q    <= req_cnt_q + 32'd1;
            scan_cnt_q   <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            evict_cnt_q  <= '0;
          end
        end
        S_LOOK: begin
          if (rd_vld_q) begin
            if (valid_q[rd_idx_q] && key_rd_q == req_key_q && !hit_q) begin
              hit_q      <= 1'b1;
              hit_rank_q <= rank_q[rd_idx_q];
            end
            if (!valid_q[rd_idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
          end
        end
        S_DECIDE: begin
          scan_cnt_q   <= '0;
          best_found_q <= 1'b0;
          if (hit_q) begin
            hit_cnt_q <= hit_cnt_q + 32'd1;
            if (policy_q == sacr_pkg::PolLru) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (valid_q[i] && rank_q[i] < hit_rank_q) rank_q[i] <= rank_q[i] + 1'b1;
                if (valid_q[i] && rank_q[i] == hit_rank_q) rank_q[i] <= '0;
              end
            end
          end
        end
        S_VICT: begin
          if (rd_vld_q && valid_q[rd_idx_q] && (!best_found_q || better)) begin
            best_found_q <= 1'b1;
            best_idx_q   <= rd_idx_q;
            best_rank_q  <= rank_q[rd_idx_q];
            best_key_q   <= key_rd_q;
            best_size_q  <= size_rd_q;
          end
        end
        S_DROP: begin
          if (emit_ok) begin
            valid_q[best_idx_q] <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (valid_q[i] && rank_q[i] > best_rank_q) rank_q[i] <= rank_q[i] - 1'b1;
            end
            free_q      <= free_drop;
            evict_cnt_q <= evict_cnt_q + 1'b1;
            if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= best_idx_q;
            end
            out_ev_q          <= 1'b1;
            out_last_q        <= 1'b0;
            out_q.evicted_key <= best_key_q;
            out_q.was_hit     <= 1'b0;
            out_q.was_stored  <= 1'b0;
            out_q.bytes_free  <= 32'(free_drop);
            out_q.hit_total   <= hit_cnt_q;
            out_q.request_total <= req_cnt_q;
          end
        end
        S_FINAL: begin
          if (emit_ok) begin
            if (do_store) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
              end
              rank_q[free_idx_q]  <= '0;
              valid_q[free_idx_q] <= 1'b1;
              free_q              <= free_ins;
            end
            out_ev_q          <= 1'b0;
            out_last_q        <= 1'b1;
            out_q.evicted_key <= '0;
            out_q.was_hit     <= hit_q;
            out_q.was_stored  <= do_store;
            out_q.bytes_free  <= do_store ? 32'(free_ins) : 32'(free_q);
            out_q.hit_total   <= hit_cnt_q;
            out_q.request_total <= req_cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= cap_q) else $error("free space above capacity");
  a_drop_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DROP) |-> best_found_q) else $error("drop without victim");
  a_evict_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_cnt_q <= SlotsC) else $error("eviction count overflow");
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && emit_ok) |=> (out_vld_q && out_last_q && !out_ev_q))
    else $error("final result not marked last");
`endif

endmodule
